// ----- rtl/rmi_pkg.sv -----
// Shared types, codes and defaults of the range merge iterator.
package rmi_pkg;

    localparam int TIME_W      = 64;
    localparam int DATA_W      = 64;
    localparam int OP_W        = 3;
    localparam int ENTRY_IDX_W = 10;
    localparam int CNT_FIELD_W = 11;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;

    localparam int DEF_STORE_DEPTH   = 1024;
    localparam int DEF_PAYLOAD_WIDTH = 64;

    typedef logic [OP_W-1:0]            t_op;
    typedef logic [STATUS_W-1:0]        t_status;
    typedef logic signed [TIME_W-1:0]   t_time;
    typedef logic [DATA_W-1:0]          t_data;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [ENTRY_IDX_W-1:0]     t_entry_idx;
    typedef logic [CNT_FIELD_W-1:0]     t_cnt;

    localparam t_op OP_WR_IN  = 3'd0;
    localparam t_op OP_WR_OUT = 3'd1;
    localparam t_op OP_START  = 3'd2;
    localparam t_op OP_NEXT   = 3'd3;
    localparam t_op OP_SEEK   = 3'd4;

    localparam t_status ST_RECORD = 2'd0;
    localparam t_status ST_END    = 2'd1;
    localparam t_status ST_ACK    = 2'd2;

    localparam t_cfg_idx CFG_START_TIME = 3'd0;
    localparam t_cfg_idx CFG_END_TIME   = 3'd1;
    localparam t_cfg_idx CFG_END_UNB    = 3'd2;
    localparam t_cfg_idx CFG_IN_COUNT   = 3'd3;
    localparam t_cfg_idx CFG_OUT_COUNT  = 3'd4;

    typedef struct packed {
        t_status status;
        t_time   record_time;
        t_data   record_payload;
    } t_result;

    typedef struct packed {
        t_op   op;
        t_time seek_target;
    } t_cmd;

    typedef struct packed {
        t_time start_time;
        t_time end_time;
        logic  end_unbounded;
    } t_window;

endpackage

// ----- rtl/rmi_if.sv -----
// Channel interfaces of the range merge iterator.
interface rmi_item_if;
    logic                valid;
    logic                ready;
    rmi_pkg::t_op        operation;
    rmi_pkg::t_entry_idx entry_index;
    rmi_pkg::t_time      entry_time;
    rmi_pkg::t_data      entry_payload;
    rmi_pkg::t_time      seek_target;

    modport source (output valid, operation, entry_index, entry_time, entry_payload,
                    seek_target, input ready);
    modport sink (input valid, operation, entry_index, entry_time, entry_payload,
                  seek_target, output ready);
endinterface

interface rmi_result_if;
    logic            valid;
    logic            ready;
    rmi_pkg::t_status status;
    rmi_pkg::t_time   record_time;
    rmi_pkg::t_data   record_payload;

    modport source (output valid, status, record_time, record_payload, input ready);
    modport sink (input valid, status, record_time, record_payload, output ready);
endinterface

interface rmi_cfg_if;
    logic              valid;
    logic              ready;
    rmi_pkg::t_cfg_idx index;
    rmi_pkg::t_data    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rmi_store.sv -----
// One record store: time and payload memories with a registered read port.
module rmi_store #(
    parameter int STORE_DEPTH   = rmi_pkg::DEF_STORE_DEPTH,
    parameter int PAYLOAD_WIDTH = rmi_pkg::DEF_PAYLOAD_WIDTH,
    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [IDX_W-1:0]         i_waddr,
    input  rmi_pkg::t_time           i_wtime,
    input  logic [PAYLOAD_WIDTH-1:0] i_wpay,
    input  logic [IDX_W-1:0]         i_raddr,
    output rmi_pkg::t_time           o_rtime,
    output logic [PAYLOAD_WIDTH-1:0] o_rpay
);

    rmi_pkg::t_time           r_time [STORE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] r_pay  [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_time[i_waddr] <= i_wtime;
            r_pay[i_waddr]  <= i_wpay;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rtime <= r_time[i_raddr];
        o_rpay  <= r_pay[i_raddr];
    end

endmodule

// ----- rtl/rmi_seq.sv -----
// Sequencer with the shared time comparator: window searches, seek and merge step.
module rmi_seq #(
    parameter int STORE_DEPTH   = rmi_pkg::DEF_STORE_DEPTH,
    parameter int PAYLOAD_WIDTH = rmi_pkg::DEF_PAYLOAD_WIDTH,
    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
    localparam int POS_W = $clog2(STORE_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  rmi_pkg::t_cmd            i_cmd,
    output logic                     o_idle,
    input  rmi_pkg::t_window         i_win,
    input  logic [POS_W-1:0]         i_in_len,
    input  logic [POS_W-1:0]         i_out_len,
    output logic [IDX_W-1:0]         o_in_raddr,
    output logic [IDX_W-1:0]         o_out_raddr,
    input  rmi_pkg::t_time           i_in_rtime,
    input  logic [PAYLOAD_WIDTH-1:0] i_in_rpay,
    input  rmi_pkg::t_time           i_out_rtime,
    input  logic [PAYLOAD_WIDTH-1:0] i_out_rpay,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output rmi_pkg::t_result         o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SK1  = 3'd1;
    localparam logic [2:0] S_SK2  = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_NCMP = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]       r_state, n_state;
    rmi_pkg::t_op     r_op, n_op;
    rmi_pkg::t_time   r_seek, n_seek;
    logic [1:0]       r_srch, n_srch;
    logic [POS_W-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [POS_W-1:0] r_pos_i, n_pos_i, r_end_i, n_end_i;
    logic [POS_W-1:0] r_pos_o, n_pos_o, r_end_o, n_end_o;
    logic             r_fin, n_fin;
    rmi_pkg::t_result r_res, n_res;

    logic [POS_W:0]   sum;
    logic [POS_W-1:0] mid;
    rmi_pkg::t_time   target, cmp_a, cmp_b;
    logic             less, idone, odone, take_in, is_start;

    assign sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = sum[POS_W:1];
    assign idone    = (r_pos_i >= r_end_i);
    assign odone    = (r_pos_o >= r_end_o);
    assign is_start = (r_op == rmi_pkg::OP_START);
    assign target   = r_srch[1] ? i_win.end_time : (is_start ? i_win.start_time : r_seek);

    // The one comparator, shared by every step that orders two times.
    always_comb begin
        unique case (r_state)
            S_CMP: begin
                cmp_a = r_srch[0] ? i_out_rtime : i_in_rtime;
                cmp_b = target;
            end
            S_NCMP: begin
                cmp_a = i_out_rtime;
                cmp_b = i_in_rtime;
            end
            S_SK1: begin
                cmp_a = i_win.start_time;
                cmp_b = r_seek;
            end
            S_SK2: begin
                cmp_a = r_seek;
                cmp_b = i_win.end_time;
            end
            S_IDLE, S_SRCH, S_FIN, S_DONE: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign less    = ($signed(cmp_a) < $signed(cmp_b));
    assign take_in = idone ? 1'b0 : (odone ? 1'b1 : !less);

    assign o_in_raddr  = (r_state == S_SRCH) ? mid[IDX_W-1:0] : r_pos_i[IDX_W-1:0];
    assign o_out_raddr = (r_state == S_SRCH) ? mid[IDX_W-1:0] : r_pos_o[IDX_W-1:0];
    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_seek  = r_seek;
        n_srch  = r_srch;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_pos_i = r_pos_i;
        n_end_i = r_end_i;
        n_pos_o = r_pos_o;
        n_end_o = r_end_o;
        n_fin   = r_fin;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_op   = i_cmd.op;
                    n_seek = i_cmd.seek_target;
                    n_srch = 2'd0;
                    n_lo   = '0;
                    n_hi   = i_in_len;
                    n_res  = '{status: rmi_pkg::ST_ACK, record_time: '0, record_payload: '0};
                    priority if (i_cmd.op == rmi_pkg::OP_START) begin
                        n_state = S_SRCH;
                    end else if (i_cmd.op == rmi_pkg::OP_NEXT) begin
                        if (r_fin || (idone && odone)) begin
                            n_fin        = 1'b1;
                            n_res.status = rmi_pkg::ST_END;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_NCMP;
                        end
                    end else if (i_cmd.op == rmi_pkg::OP_SEEK) begin
                        n_state = r_fin ? S_DONE : S_SK1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SK1: begin
                n_state = less ? S_SK2 : S_DONE;
            end
            S_SK2: begin
                if (i_win.end_unbounded || less) begin
                    n_state = S_SRCH;
                end else begin
                    n_fin   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_mid   = mid;
                    n_state = S_CMP;
                end else begin
                    n_lo = '0;
                    unique case (r_srch)
                        2'd0: begin
                            if (is_start || (r_lo > r_pos_i)) begin
                                n_pos_i = r_lo;
                            end
                            n_srch = 2'd1;
                            n_hi   = i_out_len;
                        end
                        2'd1: begin
                            if (is_start || (r_lo > r_pos_o)) begin
                                n_pos_o = r_lo;
                            end
                            if (is_start && !i_win.end_unbounded) begin
                                n_srch = 2'd2;
                                n_hi   = i_in_len;
                            end else begin
                                if (is_start) begin
                                    n_end_i = i_in_len;
                                    n_end_o = i_out_len;
                                end
                                n_state = S_FIN;
                            end
                        end
                        2'd2: begin
                            n_end_i = r_lo;
                            n_srch  = 2'd3;
                            n_hi    = i_out_len;
                        end
                        2'd3: begin
                            n_end_o = r_lo;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (less) begin
                    n_lo = r_mid + POS_W'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRCH;
            end
            S_FIN: begin
                n_fin   = idone && odone;
                n_state = S_DONE;
            end
            S_NCMP: begin
                n_res.status = rmi_pkg::ST_RECORD;
                if (take_in) begin
                    n_res.record_time    = i_in_rtime;
                    n_res.record_payload = rmi_pkg::DATA_W'(i_in_rpay);
                    n_pos_i              = r_pos_i + POS_W'(1);
                end else begin
                    n_res.record_time    = i_out_rtime;
                    n_res.record_payload = rmi_pkg::DATA_W'(i_out_rpay);
                    n_pos_o              = r_pos_o + POS_W'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos_i <= '0;
            r_end_i <= '0;
            r_pos_o <= '0;
            r_end_o <= '0;
            r_fin   <= 1'b1;
        end else begin
            r_state <= n_state;
            r_pos_i <= n_pos_i;
            r_end_i <= n_end_i;
            r_pos_o <= n_pos_o;
            r_end_o <= n_end_o;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_seek <= n_seek;
        r_srch <= n_srch;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_res  <= n_res;
    end

endmodule

// ----- rtl/range_merge_iterator.sv -----
// Top level of the range merge iterator: registers, stores, sequencer and result register.
//
//   Channel   Role   Handshake     Contents
//   i_item    sink   valid/ready   operation, entry_index, entry_time, entry_payload,
//                                  seek_target
//   o_result  source valid/ready   status, record_time, record_payload
//   i_cfg     sink   valid/ready   index, data (always ready)
//
// Writes, unused codes and requests that end at once take no search; next takes one merge step.
// One search takes at most p = ceil(log2(count + 1)) probes, each probe one memory read and one
// pass through the shared comparator; start runs four searches, or two without an end bound, and
// a seek runs two searches after its window checks, or stops after those checks.
// Reset is synchronous and needs no clearing pass; store contents are not reset.
// One request is in work at a time, and a finished result waits in the output register.
module range_merge_iterator #(
    parameter int STORE_DEPTH   = rmi_pkg::DEF_STORE_DEPTH,
    parameter int PAYLOAD_WIDTH = rmi_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rmi_item_if.sink      i_item,
    rmi_result_if.source  o_result,
    rmi_cfg_if.sink       i_cfg
);

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int POS_W = $clog2(STORE_DEPTH + 1);

    rmi_pkg::t_time r_start_time, r_end_time;
    logic           r_end_unb;
    rmi_pkg::t_cnt  r_in_cnt, r_out_cnt;

    logic                     item_acc, idle, wr_ok, we_in, we_out;
    logic [POS_W-1:0]         in_len, out_len;
    logic [IDX_W-1:0]         waddr, in_raddr, out_raddr;
    rmi_pkg::t_time           in_rtime, out_rtime;
    logic [PAYLOAD_WIDTH-1:0] in_rpay, out_rpay;
    rmi_pkg::t_window         win;
    rmi_pkg::t_cmd            cmd;
    logic                     res_valid, res_ready;
    rmi_pkg::t_result         res;
    logic                     r_out_valid;
    rmi_pkg::t_result         r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time <= '0;
            r_end_time   <= '0;
            r_end_unb    <= 1'b0;
            r_in_cnt     <= '0;
            r_out_cnt    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rmi_pkg::CFG_START_TIME: r_start_time <= i_cfg.data;
                rmi_pkg::CFG_END_TIME:   r_end_time   <= i_cfg.data;
                rmi_pkg::CFG_END_UNB:    r_end_unb    <= i_cfg.data[0];
                rmi_pkg::CFG_IN_COUNT:   r_in_cnt     <= i_cfg.data[rmi_pkg::CNT_FIELD_W-1:0];
                rmi_pkg::CFG_OUT_COUNT:  r_out_cnt    <= i_cfg.data[rmi_pkg::CNT_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    assign in_len  = (32'(r_in_cnt) > STORE_DEPTH) ? POS_W'(STORE_DEPTH) : POS_W'(r_in_cnt);
    assign out_len = (32'(r_out_cnt) > STORE_DEPTH) ? POS_W'(STORE_DEPTH) : POS_W'(r_out_cnt);

    assign i_item.ready = idle;
    assign item_acc     = i_item.valid && idle;
    assign wr_ok        = (32'(i_item.entry_index) < STORE_DEPTH);
    assign we_in        = item_acc && wr_ok && (i_item.operation == rmi_pkg::OP_WR_IN);
    assign we_out       = item_acc && wr_ok && (i_item.operation == rmi_pkg::OP_WR_OUT);
    assign waddr        = IDX_W'(i_item.entry_index);

    rmi_store #(
        .STORE_DEPTH   (STORE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_in_store (
        .i_clk   (i_clk),
        .i_we    (we_in),
        .i_waddr (waddr),
        .i_wtime (i_item.entry_time),
        .i_wpay  (i_item.entry_payload[PAYLOAD_WIDTH-1:0]),
        .i_raddr (in_raddr),
        .o_rtime (in_rtime),
        .o_rpay  (in_rpay)
    );

    rmi_store #(
        .STORE_DEPTH   (STORE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_out_store (
        .i_clk   (i_clk),
        .i_we    (we_out),
        .i_waddr (waddr),
        .i_wtime (i_item.entry_time),
        .i_wpay  (i_item.entry_payload[PAYLOAD_WIDTH-1:0]),
        .i_raddr (out_raddr),
        .o_rtime (out_rtime),
        .o_rpay  (out_rpay)
    );

    assign win = '{start_time: r_start_time, end_time: r_end_time, end_unbounded: r_end_unb};
    assign cmd = '{op: i_item.operation, seek_target: i_item.seek_target};

    rmi_seq #(
        .STORE_DEPTH   (STORE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (item_acc),
        .i_cmd       (cmd),
        .o_idle      (idle),
        .i_win       (win),
        .i_in_len    (in_len),
        .i_out_len   (out_len),
        .o_in_raddr  (in_raddr),
        .o_out_raddr (out_raddr),
        .i_in_rtime  (in_rtime),
        .i_in_rpay   (in_rpay),
        .i_out_rtime (out_rtime),
        .i_out_rpay  (out_rpay),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_out.status;
    assign o_result.record_time    = r_out.record_time;
    assign o_result.record_payload = r_out.record_payload;

endmodule
